/* rtl/core/capacitive_touch_key_detector_top_macros.svh */
// assertion macros shared by the detector
`ifndef CAPACITIVE_TOUCH_KEY_DETECTOR_TOP_MACROS_SVH
`define CAPACITIVE_TOUCH_KEY_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define CTKD_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define CTKD_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/core/ctkd_pkg.sv */
package ctkd_pkg;

  // calibration round size and averaging window
  localparam int CALIB_SAMPLES = 10;
  localparam int CALIB_CNT     = (CALIB_SAMPLES < 6) ? CALIB_SAMPLES : 6;
  localparam int CALIB_FIRST   = (CALIB_SAMPLES < 6) ? 0 : (CALIB_SAMPLES - 6) / 2;
  localparam int IDX_W         = $clog2(CALIB_SAMPLES);
  localparam int SUM_W         = $clog2(CALIB_CNT * 65536);
  localparam int CNT_W         = $clog2(CALIB_CNT + 1);

  // reciprocal of the window size, exact floor for sums below 2**SUM_W
  localparam int DIV_SH        = 24;
  localparam int RECIP_W       = DIV_SH + 1;
  localparam logic [RECIP_W-1:0] DIV_RECIP =
    RECIP_W'(((64'd1 << DIV_SH) + 64'(CALIB_CNT) - 64'd1) / 64'(CALIB_CNT));

  // register reset values
  localparam logic [15:0] GATE_RESET    = 16'd100;
  localparam logic [3:0]  SINGLE_RESET  = 4'd3;
  localparam logic [3:0]  REPEAT_RESET  = 4'd6;
  localparam logic [3:0]  LOCKOUT_RESET = 4'd3;

  // configuration register indexes
  localparam logic [2:0] REG_GATE       = 3'd0;
  localparam logic [2:0] REG_CONTINUOUS = 3'd1;
  localparam logic [2:0] REG_SINGLE     = 3'd2;
  localparam logic [2:0] REG_REPEAT     = 3'd3;
  localparam logic [2:0] REG_LOCKOUT    = 3'd4;

  // sample kinds
  localparam logic ACT_CALIB = 1'b0;
  localparam logic ACT_SCAN  = 1'b1;

  typedef logic [15:0] count_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SUM,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [15:0] gate_threshold;
    logic        continuous_mode;
    logic [3:0]  single_scan_samples;
    logic [3:0]  repeat_scan_samples;
    logic [3:0]  lockout_scans;
  } cfg_t;

  typedef struct packed {
    logic   done;
    logic   pressed;
    count_t peak;
  } scan_res_t;

  typedef struct packed {
    logic   scan_done;
    logic   key_pressed;
    logic   calib_done;
    logic   calib_fault;
    count_t baseline;
    count_t scan_peak;
  } result_t;

endpackage

/* rtl/core/ctkd_sort_cell.sv */
module ctkd_sort_cell (
  input  logic            clk,
  input  logic            ins,
  input  logic            occ,
  input  ctkd_pkg::count_t x,
  input  ctkd_pkg::count_t left_val,
  input  logic            left_keep,
  output ctkd_pkg::count_t val,
  output logic            keep
);

  // an occupied cell not above the new sample stays put
  assign keep = occ && (val <= x);

  // otherwise take the sample or the left neighbor's value
  always_ff @(posedge clk) begin
    if (ins && !keep) begin
      val <= left_keep ? x : left_val;
    end
  end

endmodule

/* rtl/core/ctkd_sort_chain.sv */
module ctkd_sort_chain (
  input  logic             clk,
  input  logic             ins,
  input  logic [3:0]       fill,
  input  ctkd_pkg::count_t x,
  output ctkd_pkg::count_t vals [ctkd_pkg::CALIB_SAMPLES]
);

  logic keeps [ctkd_pkg::CALIB_SAMPLES];

  // ascending insertion chain, cell zero holds the smallest sample
  for (genvar i = 0; i < ctkd_pkg::CALIB_SAMPLES; i++) begin : g_cell
    logic             occ;
    logic             lk;
    ctkd_pkg::count_t lv;

    assign occ = {1'b0, fill} > 5'(i);

    if (i == 0) begin : g_head
      assign lk = 1'b1;
      assign lv = x;
    end else begin : g_body
      assign lk = keeps[i-1];
      assign lv = vals[i-1];
    end

    ctkd_sort_cell u_cell (
      .clk       (clk),
      .ins       (ins),
      .occ       (occ),
      .x         (x),
      .left_val  (lv),
      .left_keep (lk),
      .val       (vals[i]),
      .keep      (keeps[i])
    );
  end

endmodule

/* rtl/core/ctkd_scan.sv */
module ctkd_scan (
  input  logic                clk,
  input  logic                rst,
  input  logic                step,
  input  ctkd_pkg::count_t    x,
  input  ctkd_pkg::count_t    baseline_value,
  input  ctkd_pkg::cfg_t      cfg,
  output ctkd_pkg::scan_res_t res
);

  logic [3:0]       scan_fill;
  logic [3:0]       scan_fill_next;
  ctkd_pkg::count_t scan_max;
  ctkd_pkg::count_t scan_max_next;
  logic [3:0]       lockout_count;
  logic [3:0]       lockout_count_next;

  logic [3:0]       n_raw;
  logic [3:0]       n;
  ctkd_pkg::count_t m;
  logic             done;
  logic [3:0]       lock0;
  logic [3:0]       lock1;
  logic             qual;
  logic [16:0]      floor_lvl;
  logic [19:0]      ceil_lvl;

  // group length and running peak
  always_comb begin
    n_raw = cfg.continuous_mode ? cfg.repeat_scan_samples : cfg.single_scan_samples;
    n     = (n_raw == 4'd0) ? 4'd1 : n_raw;
    m     = (x > scan_max) ? x : scan_max;
    done  = ({1'b0, scan_fill} + 5'd1) >= {1'b0, n};
  end

  // press window and lockout
  always_comb begin
    floor_lvl = {1'b0, baseline_value} + {1'b0, cfg.gate_threshold};
    ceil_lvl  = {1'b0, baseline_value, 3'b000} + {3'b000, baseline_value, 1'b0};
    qual      = ({1'b0, m} > floor_lvl) && ({4'b0000, m} < ceil_lvl);
    lock0     = cfg.continuous_mode ? 4'd0 : lockout_count;
    lock1     = qual ? cfg.lockout_scans : lock0;

    res.done    = done;
    res.pressed = done && qual && (lock0 == 4'd0);
    res.peak    = done ? m : '0;

    if (done) begin
      scan_fill_next     = 4'd0;
      scan_max_next      = '0;
      lockout_count_next = (lock1 != 4'd0) ? lock1 - 4'd1 : 4'd0;
    end else begin
      scan_fill_next     = scan_fill + 4'd1;
      scan_max_next      = m;
      lockout_count_next = lockout_count;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_fill     <= 4'd0;
      scan_max      <= '0;
      lockout_count <= 4'd0;
    end else if (step) begin
      scan_fill     <= scan_fill_next;
      scan_max      <= scan_max_next;
      lockout_count <= lockout_count_next;
    end
  end

endmodule

/* rtl/core/capacitive_touch_key_detector_top.sv */
// scan samples and non-final calibration samples: result registered into the output register after accept,
// or into the skid entry while the output stalls; one request per cycle while the output drains
// final calibration sample: the sum state adds one sorted cell per cycle from the middle window,
// a divide state multiplies the sum by the reciprocal, and the done state writes the average
// reset clears state, valid flags, fill counters, baseline and lockout; the sorted cells are not cleared
`include "capacitive_touch_key_detector_top_macros.svh"

module capacitive_touch_key_detector_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        action,
  input  logic [15:0] charge_count,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        scan_done,
  output logic        key_pressed,
  output logic        calib_done,
  output logic        calib_fault,
  output logic [15:0] baseline,
  output logic [15:0] scan_peak,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  ctkd_pkg::cfg_t      cfg;
  ctkd_pkg::state_t    state;
  ctkd_pkg::state_t    state_next;
  ctkd_pkg::count_t    baseline_value;
  logic [3:0]          calib_fill;
  logic [ctkd_pkg::CNT_W-1:0] sum_cnt;
  logic [ctkd_pkg::SUM_W-1:0] sum;
  logic [ctkd_pkg::SUM_W+ctkd_pkg::RECIP_W-1:0] prod;
  ctkd_pkg::count_t    quot;
  ctkd_pkg::count_t    cells [ctkd_pkg::CALIB_SAMPLES];
  logic [ctkd_pkg::IDX_W-1:0] sel;
  ctkd_pkg::scan_res_t scan_res;
  ctkd_pkg::result_t   res;
  ctkd_pkg::result_t   pend;
  ctkd_pkg::result_t   out_reg;
  logic                pend_valid;
  logic                res_we;
  logic                out_free;
  logic                accept;
  logic                calib_last;

  // configuration registers, always ready
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.gate_threshold      <= ctkd_pkg::GATE_RESET;
      cfg.continuous_mode     <= 1'b0;
      cfg.single_scan_samples <= ctkd_pkg::SINGLE_RESET;
      cfg.repeat_scan_samples <= ctkd_pkg::REPEAT_RESET;
      cfg.lockout_scans       <= ctkd_pkg::LOCKOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ctkd_pkg::REG_GATE:       cfg.gate_threshold      <= cfg_data;
        ctkd_pkg::REG_CONTINUOUS: cfg.continuous_mode     <= cfg_data[0];
        ctkd_pkg::REG_SINGLE:     cfg.single_scan_samples <= cfg_data[3:0];
        ctkd_pkg::REG_REPEAT:     cfg.repeat_scan_samples <= cfg_data[3:0];
        ctkd_pkg::REG_LOCKOUT:    cfg.lockout_scans       <= cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign in_stall   = !((state == ctkd_pkg::ST_IDLE) && !pend_valid);
  assign accept     = in_valid && !in_stall;
  assign calib_last = ({1'b0, calib_fill} + 5'd1) >= 5'(ctkd_pkg::CALIB_SAMPLES);

  // sorted calibration cells
  ctkd_sort_chain u_chain (
    .clk  (clk),
    .ins  (accept && (action == ctkd_pkg::ACT_CALIB)),
    .fill (calib_fill),
    .x    (charge_count),
    .vals (cells)
  );

  // scan grouping and press decision
  ctkd_scan u_scan (
    .clk            (clk),
    .rst            (rst),
    .step           (accept && (action == ctkd_pkg::ACT_SCAN)),
    .x              (charge_count),
    .baseline_value (baseline_value),
    .cfg            (cfg),
    .res            (scan_res)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ctkd_pkg::ST_IDLE: begin
        if (accept && (action == ctkd_pkg::ACT_CALIB) && calib_last) begin
          state_next = ctkd_pkg::ST_SUM;
        end
      end
      ctkd_pkg::ST_SUM: begin
        if (sum_cnt == ctkd_pkg::CNT_W'(ctkd_pkg::CALIB_CNT - 1)) begin
          state_next = ctkd_pkg::ST_DIV;
        end
      end
      ctkd_pkg::ST_DIV:  state_next = ctkd_pkg::ST_DONE;
      ctkd_pkg::ST_DONE: state_next = ctkd_pkg::ST_IDLE;
      default:           state_next = ctkd_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ctkd_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // calibration fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      calib_fill <= 4'd0;
    end else if (accept && (action == ctkd_pkg::ACT_CALIB)) begin
      calib_fill <= calib_last ? 4'd0 : calib_fill + 4'd1;
    end
  end

  // walk the middle cells, then scale by the reciprocal
  assign sel  = ctkd_pkg::IDX_W'(ctkd_pkg::CALIB_FIRST) + ctkd_pkg::IDX_W'(sum_cnt);
  assign quot = prod[ctkd_pkg::DIV_SH +: 16];

  always_ff @(posedge clk) begin
    if (rst) begin
      sum_cnt <= '0;
    end else if (state == ctkd_pkg::ST_SUM) begin
      sum_cnt <= (state_next == ctkd_pkg::ST_SUM) ? sum_cnt + 1'b1 : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ctkd_pkg::ST_IDLE) begin
      sum <= '0;
    end else if (state == ctkd_pkg::ST_SUM) begin
      sum <= sum + ctkd_pkg::SUM_W'(cells[sel]);
    end
    if (state == ctkd_pkg::ST_DIV) begin
      prod <= sum * ctkd_pkg::DIV_RECIP;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      baseline_value <= '0;
    end else if (state == ctkd_pkg::ST_DONE) begin
      baseline_value <= quot;
    end
  end

  // result of this cycle
  always_comb begin
    res        = '0;
    res_we     = 1'b0;
    res.baseline = baseline_value;
    if (state == ctkd_pkg::ST_DONE) begin
      res_we          = 1'b1;
      res.calib_done  = 1'b1;
      res.calib_fault = quot[15];
      res.baseline    = quot;
    end else if (accept) begin
      if (action == ctkd_pkg::ACT_SCAN) begin
        res_we          = 1'b1;
        res.scan_done   = scan_res.done;
        res.key_pressed = scan_res.pressed;
        res.scan_peak   = scan_res.peak;
      end else begin
        res_we = !calib_last;
      end
    end
  end

  // output register with one skid entry behind it
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      pend_valid <= 1'b0;
    end else if (out_free) begin
      if (pend_valid) begin
        out_valid  <= 1'b1;
        pend_valid <= res_we;
      end else begin
        out_valid  <= res_we;
      end
    end else if (res_we) begin
      pend_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      if (pend_valid) begin
        out_reg <= pend;
        if (res_we) begin
          pend <= res;
        end
      end else if (res_we) begin
        out_reg <= res;
      end
    end else if (res_we) begin
      pend <= res;
    end
  end

  assign scan_done   = out_reg.scan_done;
  assign key_pressed = out_reg.key_pressed;
  assign calib_done  = out_reg.calib_done;
  assign calib_fault = out_reg.calib_fault;
  assign baseline    = out_reg.baseline;
  assign scan_peak   = out_reg.scan_peak;

  // checks
  `CTKD_ASSERT_IMP(a_no_overrun, pend_valid && !out_free, !res_we, "skid entry overrun")
  `CTKD_ASSERT_NXT(a_calib_start,
    accept && (action == ctkd_pkg::ACT_CALIB) && calib_last,
    state == ctkd_pkg::ST_SUM, "final calibration sample did not start the sum")
  `CTKD_ASSERT_IMP(a_scan_fields, out_valid && !scan_done,
    !key_pressed && (scan_peak == 16'd0), "press fields set without a finished scan")
  `CTKD_ASSERT_IMP(a_fault_fields, out_valid && !calib_done, !calib_fault,
    "fault set without a finished calibration")

endmodule
